[rtl/mips32_pkg.sv]
// Package with opcodes, function codes and shared types of the MIPS32 execute block.
`timescale 1ns / 1ps
package mips32_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'b001100;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_DIVU    = 6'h1b;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    localparam logic [4:0] RT_BLTZ    = 5'h00;
    localparam logic [4:0] RT_BGEZ    = 5'h01;
    localparam logic [4:0] RT_BLTZAL  = 5'h10;
    localparam logic [4:0] RT_BGEZAL  = 5'h11;

    localparam logic [4:0]  REG_V0    = 5'd2;
    localparam logic [4:0]  REG_RA    = 5'd31;
    localparam logic [31:0] EXIT_CODE = 32'h0000_000a;

    typedef struct packed {
        logic start;
        logic is_div;
        logic is_signed;
    } md_req_t;

endpackage

[rtl/mips32_if.sv]
// Channel interfaces of the MIPS32 execute block.
`timescale 1ns / 1ps
interface mips32_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] instr_word;
    logic [9:0]  preload_index;
    logic [31:0] preload_data;
    modport source (output valid, mode, instr_word, preload_index, preload_data, input ready);
    modport sink (input valid, mode, instr_word, preload_index, preload_data, output ready);
endinterface

interface mips32_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pc_next;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_byte_addr;
    logic        halted;
    logic        illegal;
    modport source (output valid, pc_next, reg_write, reg_index, reg_value, mem_write,
                    mem_byte_addr, halted, illegal, input ready);
    modport sink (input valid, pc_next, reg_write, reg_index, reg_value, mem_write,
                  mem_byte_addr, halted, illegal, output ready);
endinterface

interface mips32_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/mips32_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module mips32_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mips32_md.sv]
// Iterative multiply and divide unit, one bit per cycle.
`timescale 1ns / 1ps
module mips32_md
    import mips32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  md_req_t     req,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] hi,
    output logic [31:0] lo
);

    typedef enum logic [1:0] {MD_IDLE, MD_RUN, MD_FIX} md_state_t;

    md_state_t   state_reg;
    logic [4:0]  cnt_reg;
    logic        div_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        done_reg;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic [31:0] op_reg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] mul_sum;
    logic [32:0] rem_sh;
    logic [32:0] rem_diff;
    logic [63:0] prod_neg;

    assign mag_a    = (req.is_signed && a[31]) ? 32'd0 - a : a;
    assign mag_b    = (req.is_signed && b[31]) ? 32'd0 - b : b;
    assign mul_sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, op_reg} : 33'd0);
    assign rem_sh   = {hi_reg, lo_reg[31]};
    assign rem_diff = rem_sh - {1'b0, op_reg};
    assign prod_neg = 64'd0 - {hi_reg, lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                MD_IDLE:
                begin
                    if (req.start)
                    begin
                        div_reg   <= req.is_div;
                        neg_q_reg <= req.is_signed && (a[31] ^ b[31]);
                        neg_r_reg <= req.is_signed && a[31];
                        hi_reg    <= '0;
                        lo_reg    <= req.is_div ? mag_a : mag_b;
                        op_reg    <= req.is_div ? mag_b : mag_a;
                        cnt_reg   <= '0;
                        state_reg <= MD_RUN;
                    end
                end
                MD_RUN:
                begin
                    if (div_reg)
                    begin
                        if (!rem_diff[32])
                        begin
                            hi_reg <= rem_diff[31:0];
                            lo_reg <= {lo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            hi_reg <= rem_sh[31:0];
                            lo_reg <= {lo_reg[30:0], 1'b0};
                        end
                    end
                    else
                    begin
                        {hi_reg, lo_reg} <= {mul_sum, lo_reg[31:1]};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= MD_FIX;
                    end
                end
                MD_FIX:
                begin
                    if (div_reg)
                    begin
                        if (neg_q_reg)
                        begin
                            lo_reg <= 32'd0 - lo_reg;
                        end
                        if (neg_r_reg)
                        begin
                            hi_reg <= 32'd0 - hi_reg;
                        end
                    end
                    else if (neg_q_reg)
                    begin
                        {hi_reg, lo_reg} <= prod_neg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= MD_IDLE;
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

[rtl/mips32_instruction_execute_top.sv]
// Top level of the multi-cycle MIPS32 instruction execute block.
//
//   channel  role  moves
//   instr    sink  one instruction or preload word
//   result   src   one execution report word
//   cfg      sink  start_pc register value
//
// An instruction's result is valid after register file read, execute, data store
// read and writeback. MULT, MULTU, DIV and DIVU use the bit-serial multiply and
// divide unit in place of the data store read. A preload word goes to writeback.
// The register file and the data store are synchronous RAMs; register valid bits
// make the register file read as zero after reset. A stalled result holds the
// writeback step, and a new word is taken only when the block is idle.
`timescale 1ns / 1ps
module mips32_instruction_execute_top
    import mips32_pkg::*;
#(
    parameter int          DMEM_WORDS = 1024,
    parameter logic [31:0] START_PC   = 32'h0040_0000
) (
    input  logic         clk,
    input  logic         rst_n,
    mips32_in_if.sink    instr,
    mips32_out_if.source result,
    mips32_cfg_if.sink   cfg
);

    localparam int AW = $clog2(DMEM_WORDS);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MULDIV, S_MEM, S_WB} state_t;

    state_t      state_reg;
    logic [31:0] start_pc_reg;
    logic [31:0] pc_reg;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic        halt_reg;
    logic [31:0] r2_reg;
    logic [31:0] rf_valid_reg;
    logic [31:0] iw_reg;
    logic        mode_reg;
    logic [9:0]  pidx_reg;
    logic [31:0] pdata_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] ea_reg;
    logic [31:0] word_reg;

    logic        out_valid_reg;
    logic [31:0] out_pc_reg;
    logic        out_wr_reg;
    logic [4:0]  out_idx_reg;
    logic [31:0] out_val_reg;
    logic        out_mw_reg;
    logic [31:0] out_addr_reg;
    logic        out_halt_reg;
    logic        out_ill_reg;

    logic [31:0] rf_qa;
    logic [31:0] rf_qb;
    logic [31:0] dm_q;
    logic        rf_we;
    logic        dm_we;
    logic [AW-1:0] dm_waddr;
    logic [31:0] dm_wdata;
    logic [AW-1:0] dm_raddr;

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [5:0]  fn;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [31:0] link;
    logic [31:0] btarget;
    logic [31:0] ea_calc;
    logic [4:0]  bsh;
    logic [4:0]  hsh;
    logic        is_md;
    logic        run;
    logic        wb_go;

    logic [31:0] npc;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        mw;
    logic [31:0] maddr;
    logic        ill;
    logic        halt_set;
    logic        hi_we;
    logic        lo_we;
    logic [31:0] sdata;

    md_req_t     md_req;
    logic        md_done;
    logic [31:0] md_hi;
    logic [31:0] md_lo;

    assign op      = iw_reg[31:26];
    assign rs      = iw_reg[25:21];
    assign rt      = iw_reg[20:16];
    assign rd      = iw_reg[15:11];
    assign sa      = iw_reg[10:6];
    assign fn      = iw_reg[5:0];
    assign imm     = {16'd0, iw_reg[15:0]};
    assign simm    = {{16{iw_reg[15]}}, iw_reg[15:0]};
    assign link    = pc_reg + 32'd4;
    assign btarget = link + {simm[29:0], 2'b00};
    assign ea_calc = a_reg + simm;
    assign bsh     = {ea_reg[1:0], 3'b000};
    assign hsh     = {ea_reg[1], 4'b0000};
    assign run     = !mode_reg && !halt_reg;
    assign is_md   = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU ||
                                            fn == FN_DIV || fn == FN_DIVU);
    assign wb_go   = (state_reg == S_WB) && (!out_valid_reg || result.ready);

    assign md_req.start     = (state_reg == S_EXEC) && run && is_md;
    assign md_req.is_div    = (fn == FN_DIV) || (fn == FN_DIVU);
    assign md_req.is_signed = (fn == FN_MULT) || (fn == FN_DIV);

    mips32_md u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .a     (a_reg),
        .b     (b_reg),
        .done  (md_done),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    mips32_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (widx),
        .wdata (wval),
        .raddr (instr.instr_word[25:21]),
        .rdata (rf_qa)
    );

    mips32_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (widx),
        .wdata (wval),
        .raddr (instr.instr_word[20:16]),
        .rdata (rf_qb)
    );

    mips32_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (dm_raddr),
        .rdata (dm_q)
    );

    assign rf_we    = wb_go && wr;
    assign dm_we    = wb_go && (mode_reg || mw);
    assign dm_waddr = mode_reg ? AW'(pidx_reg) : ea_reg[AW+1:2];
    assign dm_wdata = mode_reg ? pdata_reg : sdata;
    assign dm_raddr = ea_calc[AW+1:2];

    always_comb
    begin
        npc      = link;
        wr       = 1'b0;
        widx     = rt;
        wval     = '0;
        mw       = 1'b0;
        maddr    = '0;
        ill      = 1'b0;
        halt_set = 1'b0;
        hi_we    = 1'b0;
        lo_we    = 1'b0;
        sdata    = b_reg;
        if (op == OP_SPECIAL)
        begin
            wr   = 1'b1;
            widx = rd;
            case (fn)
                FN_SLL:  wval = b_reg << sa;
                FN_SRL:  wval = b_reg >> sa;
                FN_SRA:  wval = $unsigned($signed(b_reg) >>> sa);
                FN_SLLV: wval = b_reg << a_reg[4:0];
                FN_SRLV: wval = b_reg >> a_reg[4:0];
                FN_SRAV: wval = $unsigned($signed(b_reg) >>> a_reg[4:0]);
                FN_JR:
                begin
                    wr  = 1'b0;
                    npc = a_reg;
                end
                FN_JALR:
                begin
                    wval = link;
                    npc  = a_reg;
                end
                FN_ADD, FN_ADDU: wval = a_reg + b_reg;
                FN_SUB, FN_SUBU: wval = a_reg - b_reg;
                FN_AND:  wval = a_reg & b_reg;
                FN_OR:   wval = a_reg | b_reg;
                FN_XOR:  wval = a_reg ^ b_reg;
                FN_NOR:  wval = ~(a_reg | b_reg);
                FN_SLT:  wval = {31'd0, $signed(a_reg) < $signed(b_reg)};
                FN_SLTU: wval = {31'd0, a_reg < b_reg};
                FN_MFHI: wval = hi_reg;
                FN_MFLO: wval = lo_reg;
                FN_MTHI:
                begin
                    wr    = 1'b0;
                    hi_we = 1'b1;
                end
                FN_MTLO:
                begin
                    wr    = 1'b0;
                    lo_we = 1'b1;
                end
                FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: wr = 1'b0;
                FN_SYSCALL:
                begin
                    wr       = 1'b0;
                    halt_set = (r2_reg == EXIT_CODE);
                end
                default:
                begin
                    wr  = 1'b0;
                    ill = 1'b1;
                end
            endcase
        end
        else
        begin
            case (op)
                OP_J:    npc = {pc_reg[31:28], iw_reg[25:0], 2'b00};
                OP_JAL:
                begin
                    npc  = {pc_reg[31:28], iw_reg[25:0], 2'b00};
                    wr   = 1'b1;
                    widx = REG_RA;
                    wval = link;
                end
                OP_BEQ:  npc = (a_reg == b_reg) ? btarget : link;
                OP_BNE:  npc = (a_reg != b_reg) ? btarget : link;
                OP_BLEZ: npc = (a_reg[31] || a_reg == 32'd0) ? btarget : link;
                OP_BGTZ: npc = (!a_reg[31] && a_reg != 32'd0) ? btarget : link;
                OP_REGIMM:
                begin
                    if (rt == RT_BLTZ || rt == RT_BLTZAL)
                    begin
                        npc = a_reg[31] ? btarget : link;
                    end
                    else if (rt == RT_BGEZ || rt == RT_BGEZAL)
                    begin
                        npc = a_reg[31] ? link : btarget;
                    end
                    else
                    begin
                        ill = 1'b1;
                    end
                    if (rt == RT_BLTZAL || rt == RT_BGEZAL)
                    begin
                        wr   = 1'b1;
                        widx = REG_RA;
                        wval = link;
                    end
                end
                OP_ADDI, OP_ADDIU:
                begin
                    wr   = 1'b1;
                    wval = a_reg + simm;
                end
                OP_SLTI:
                begin
                    wr   = 1'b1;
                    wval = {31'd0, $signed(a_reg) < $signed(simm)};
                end
                OP_SLTIU:
                begin
                    wr   = 1'b1;
                    wval = {31'd0, a_reg < simm};
                end
                OP_ANDI:
                begin
                    wr   = 1'b1;
                    wval = a_reg & imm;
                end
                OP_ORI:
                begin
                    wr   = 1'b1;
                    wval = a_reg | imm;
                end
                OP_XORI:
                begin
                    wr   = 1'b1;
                    wval = a_reg ^ imm;
                end
                OP_LUI:
                begin
                    wr   = 1'b1;
                    wval = {iw_reg[15:0], 16'd0};
                end
                OP_LB:
                begin
                    wr    = 1'b1;
                    maddr = ea_reg;
                    wval  = {{24{word_reg[bsh + 5'd7]}}, 8'(word_reg >> bsh)};
                end
                OP_LH:
                begin
                    wr    = 1'b1;
                    maddr = ea_reg;
                    wval  = {{16{word_reg[hsh + 5'd15]}}, 16'(word_reg >> hsh)};
                end
                OP_LW:
                begin
                    wr    = 1'b1;
                    maddr = ea_reg;
                    wval  = word_reg;
                end
                OP_LBU:
                begin
                    wr    = 1'b1;
                    maddr = ea_reg;
                    wval  = {24'd0, 8'(word_reg >> bsh)};
                end
                OP_LHU:
                begin
                    wr    = 1'b1;
                    maddr = ea_reg;
                    wval  = {16'd0, 16'(word_reg >> hsh)};
                end
                OP_SB:
                begin
                    mw    = 1'b1;
                    maddr = ea_reg;
                    sdata = (word_reg & ~(32'h0000_00ff << bsh)) |
                            ({24'd0, b_reg[7:0]} << bsh);
                end
                OP_SH:
                begin
                    mw    = 1'b1;
                    maddr = ea_reg;
                    sdata = (word_reg & ~(32'h0000_ffff << hsh)) |
                            ({16'd0, b_reg[15:0]} << hsh);
                end
                OP_SW:
                begin
                    mw    = 1'b1;
                    maddr = ea_reg;
                end
                default: ill = 1'b1;
            endcase
        end
        if (!wr || widx == 5'd0)
        begin
            wr   = 1'b0;
            widx = '0;
            wval = '0;
        end
        if (!run)
        begin
            npc      = pc_reg;
            wr       = 1'b0;
            widx     = '0;
            wval     = '0;
            mw       = 1'b0;
            maddr    = '0;
            ill      = 1'b0;
            halt_set = 1'b0;
            hi_we    = 1'b0;
            lo_we    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_pc_reg  <= START_PC;
            pc_reg        <= START_PC;
            hi_reg        <= '0;
            lo_reg        <= '0;
            halt_reg      <= 1'b0;
            r2_reg        <= '0;
            rf_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                start_pc_reg <= cfg.data;
            end
            if (out_valid_reg && result.ready && !wb_go)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (instr.valid)
                    begin
                        iw_reg    <= instr.instr_word;
                        mode_reg  <= instr.mode;
                        pidx_reg  <= instr.preload_index;
                        pdata_reg <= instr.preload_data;
                        state_reg <= instr.mode ? S_WB : S_READ;
                    end
                end
                S_READ:
                begin
                    a_reg     <= (rs != 5'd0 && rf_valid_reg[rs]) ? rf_qa : 32'd0;
                    b_reg     <= (rt != 5'd0 && rf_valid_reg[rt]) ? rf_qb : 32'd0;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    ea_reg    <= ea_calc;
                    state_reg <= md_req.start ? S_MULDIV : S_MEM;
                end
                S_MULDIV:
                begin
                    if (md_done)
                    begin
                        if (!(md_req.is_div && b_reg == 32'd0))
                        begin
                            hi_reg <= md_hi;
                            lo_reg <= md_lo;
                        end
                        state_reg <= S_WB;
                    end
                end
                S_MEM:
                begin
                    word_reg  <= dm_q;
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (wb_go)
                    begin
                        if (!mode_reg)
                        begin
                            pc_reg <= npc;
                        end
                        if (hi_we)
                        begin
                            hi_reg <= a_reg;
                        end
                        if (lo_we)
                        begin
                            lo_reg <= a_reg;
                        end
                        if (halt_set)
                        begin
                            halt_reg <= 1'b1;
                        end
                        if (wr)
                        begin
                            rf_valid_reg[widx] <= 1'b1;
                            if (widx == REG_V0)
                            begin
                                r2_reg <= wval;
                            end
                        end
                        out_valid_reg <= 1'b1;
                        out_pc_reg    <= npc;
                        out_wr_reg    <= wr;
                        out_idx_reg   <= widx;
                        out_val_reg   <= wval;
                        out_mw_reg    <= mw;
                        out_addr_reg  <= maddr;
                        out_halt_reg  <= halt_reg || halt_set;
                        out_ill_reg   <= ill;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign instr.ready          = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign result.valid         = out_valid_reg;
    assign result.pc_next       = out_pc_reg;
    assign result.reg_write     = out_wr_reg;
    assign result.reg_index     = out_idx_reg;
    assign result.reg_value     = out_val_reg;
    assign result.mem_write     = out_mw_reg;
    assign result.mem_byte_addr = out_addr_reg;
    assign result.halted        = out_halt_reg;
    assign result.illegal       = out_ill_reg;

`ifndef SYNTHESIS
    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.reg_write && result.reg_index == 5'd0))
        else $error("Register zero reported as written.");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("Halt flag cleared.");

    a_zero_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("Register zero marked as written.");

    a_wb_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        wb_go |=> result.valid && state_reg == S_IDLE)
        else $error("Writeback did not produce a result.");
`endif

endmodule

[sim/mips32_execute_checker.sv]
// Checker that predicts and compares every execution report of the MIPS32 execute block.
`timescale 1ns / 1ps
module mips32_execute_checker
    import mips32_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    mips32_in_if  in_ch,
    mips32_out_if res_ch,
    mips32_cfg_if cfg_ch,
    output int    errors,
    output int    pending
);

    typedef struct packed {
        logic [31:0] pc_next;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_byte_addr;
        logic        halted;
        logic        illegal;
    } exec_report_t;

    exec_report_t report_q[$];
    logic [31:0]  gpr [32];
    logic [31:0]  hi_r;
    logic [31:0]  lo_r;
    logic [31:0]  pc_r;
    logic [31:0]  start_pc_r;
    logic         halt_r;
    logic [31:0]  dmem [1024];
    int           n_results;

    initial begin
        errors    = 0;
        pending   = 0;
        n_results = 0;
    end

    function automatic exec_report_t execute_word(logic mode, logic [31:0] iw,
                                                  logic [9:0] pidx, logic [31:0] pdata);
        exec_report_t r;
        logic [5:0]   op;
        logic [5:0]   fn;
        logic [4:0]   rs;
        logic [4:0]   rt;
        logic [4:0]   rd;
        logic [4:0]   sa;
        logic [4:0]   widx;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  imm;
        logic [31:0]  simm;
        logic [31:0]  link;
        logic [31:0]  btarget;
        logic [31:0]  ea;
        logic [31:0]  word;
        logic [31:0]  lane;
        logic [31:0]  npc;
        logic [31:0]  wval;
        logic [31:0]  maddr;
        logic [31:0]  ma;
        logic [31:0]  mb;
        logic [31:0]  q;
        logic [31:0]  rm;
        logic [9:0]   slot;
        logic [4:0]   bsh;
        logic [4:0]   hsh;
        logic [63:0]  prod;
        logic         wr;
        logic         mw;
        logic         ill;
        npc   = pc_r;
        wr    = 1'b0;
        mw    = 1'b0;
        ill   = 1'b0;
        widx  = '0;
        wval  = '0;
        maddr = '0;
        if (mode) begin
            dmem[pidx] = pdata;
        end else if (!halt_r) begin
            op      = iw[31:26];
            rs      = iw[25:21];
            rt      = iw[20:16];
            rd      = iw[15:11];
            sa      = iw[10:6];
            fn      = iw[5:0];
            a       = gpr[rs];
            b       = gpr[rt];
            imm     = {16'h0000, iw[15:0]};
            simm    = {{16{iw[15]}}, iw[15:0]};
            link    = pc_r + 32'd4;
            btarget = link + (simm << 2);
            npc     = link;
            if (op == OP_SPECIAL) begin
                wr   = 1'b1;
                widx = rd;
                case (fn)
                    FN_SLL:  wval = b << sa;
                    FN_SRL:  wval = b >> sa;
                    FN_SRA:  wval = $signed(b) >>> sa;
                    FN_SLLV: wval = b << a[4:0];
                    FN_SRLV: wval = b >> a[4:0];
                    FN_SRAV: wval = $signed(b) >>> a[4:0];
                    FN_JR:
                    begin
                        wr  = 1'b0;
                        npc = a;
                    end
                    FN_JALR:
                    begin
                        wval = link;
                        npc  = a;
                    end
                    FN_ADD, FN_ADDU: wval = a + b;
                    FN_SUB, FN_SUBU: wval = a - b;
                    FN_AND:  wval = a & b;
                    FN_OR:   wval = a | b;
                    FN_XOR:  wval = a ^ b;
                    FN_NOR:  wval = ~(a | b);
                    FN_SLT:  wval = {31'b0, $signed(a) < $signed(b)};
                    FN_SLTU: wval = {31'b0, a < b};
                    FN_MFHI: wval = hi_r;
                    FN_MFLO: wval = lo_r;
                    FN_MTHI:
                    begin
                        wr   = 1'b0;
                        hi_r = a;
                    end
                    FN_MTLO:
                    begin
                        wr   = 1'b0;
                        lo_r = a;
                    end
                    FN_MULT:
                    begin
                        wr   = 1'b0;
                        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                        hi_r = prod[63:32];
                        lo_r = prod[31:0];
                    end
                    FN_MULTU:
                    begin
                        wr   = 1'b0;
                        prod = {32'b0, a} * {32'b0, b};
                        hi_r = prod[63:32];
                        lo_r = prod[31:0];
                    end
                    FN_DIV:
                    begin
                        wr = 1'b0;
                        if (b != 0) begin
                            ma = a[31] ? -a : a;
                            mb = b[31] ? -b : b;
                            q  = ma / mb;
                            rm = ma % mb;
                            if (a[31] ^ b[31]) q = -q;
                            if (a[31]) rm = -rm;
                            lo_r = q;
                            hi_r = rm;
                        end
                    end
                    FN_DIVU:
                    begin
                        wr = 1'b0;
                        if (b != 0) begin
                            lo_r = a / b;
                            hi_r = a % b;
                        end
                    end
                    FN_SYSCALL:
                    begin
                        wr = 1'b0;
                        if (gpr[REG_V0] == EXIT_CODE) halt_r = 1'b1;
                    end
                    default:
                    begin
                        wr  = 1'b0;
                        ill = 1'b1;
                    end
                endcase
            end else begin
                ea   = a + simm;
                slot = ea[11:2];
                word = dmem[slot];
                bsh  = {ea[1:0], 3'b000};
                hsh  = {ea[1], 4'b0000};
                widx = rt;
                case (op)
                    OP_J: npc = {pc_r[31:28], iw[25:0], 2'b00};
                    OP_JAL:
                    begin
                        npc  = {pc_r[31:28], iw[25:0], 2'b00};
                        wr   = 1'b1;
                        widx = REG_RA;
                        wval = link;
                    end
                    OP_BEQ:  if (a == b) npc = btarget;
                    OP_BNE:  if (a != b) npc = btarget;
                    OP_BLEZ: if (a[31] || a == 0) npc = btarget;
                    OP_BGTZ: if (!a[31] && a != 0) npc = btarget;
                    OP_REGIMM:
                    begin
                        if (rt == RT_BLTZ || rt == RT_BLTZAL) begin
                            if (a[31]) npc = btarget;
                        end else if (rt == RT_BGEZ || rt == RT_BGEZAL) begin
                            if (!a[31]) npc = btarget;
                        end else begin
                            ill = 1'b1;
                        end
                        if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
                            wr   = 1'b1;
                            widx = REG_RA;
                            wval = link;
                        end
                    end
                    OP_ADDI, OP_ADDIU:
                    begin
                        wr   = 1'b1;
                        wval = a + simm;
                    end
                    OP_SLTI:
                    begin
                        wr   = 1'b1;
                        wval = {31'b0, $signed(a) < $signed(simm)};
                    end
                    OP_SLTIU:
                    begin
                        wr   = 1'b1;
                        wval = {31'b0, a < simm};
                    end
                    OP_ANDI:
                    begin
                        wr   = 1'b1;
                        wval = a & imm;
                    end
                    OP_ORI:
                    begin
                        wr   = 1'b1;
                        wval = a | imm;
                    end
                    OP_XORI:
                    begin
                        wr   = 1'b1;
                        wval = a ^ imm;
                    end
                    OP_LUI:
                    begin
                        wr   = 1'b1;
                        wval = {iw[15:0], 16'h0000};
                    end
                    OP_LB, OP_LBU:
                    begin
                        wr    = 1'b1;
                        maddr = ea;
                        lane  = word >> bsh;
                        wval  = (op == OP_LB) ? {{24{lane[7]}}, lane[7:0]} : {24'b0, lane[7:0]};
                    end
                    OP_LH, OP_LHU:
                    begin
                        wr    = 1'b1;
                        maddr = ea;
                        lane  = word >> hsh;
                        wval  = (op == OP_LH) ? {{16{lane[15]}}, lane[15:0]}
                                              : {16'b0, lane[15:0]};
                    end
                    OP_LW:
                    begin
                        wr    = 1'b1;
                        maddr = ea;
                        wval  = word;
                    end
                    OP_SB:
                    begin
                        mw         = 1'b1;
                        maddr      = ea;
                        dmem[slot] = (word & ~(32'hff << bsh)) | ((b & 32'hff) << bsh);
                    end
                    OP_SH:
                    begin
                        mw         = 1'b1;
                        maddr      = ea;
                        dmem[slot] = (word & ~(32'hffff << hsh)) | ((b & 32'hffff) << hsh);
                    end
                    OP_SW:
                    begin
                        mw         = 1'b1;
                        maddr      = ea;
                        dmem[slot] = b;
                    end
                    default: ill = 1'b1;
                endcase
            end
            if (!wr || widx == 0) begin
                wr   = 1'b0;
                widx = '0;
                wval = '0;
            end else begin
                gpr[widx] = wval;
            end
            pc_r = npc;
        end
        r.pc_next       = npc;
        r.reg_write     = wr;
        r.reg_index     = widx;
        r.reg_value     = wval;
        r.mem_write     = mw;
        r.mem_byte_addr = maddr;
        r.halted        = halt_r;
        r.illegal       = ill;
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        exec_report_t want;
        if (!rst_n) begin
            for (int i = 0; i < 32; i++) gpr[i] = '0;
            hi_r       = '0;
            lo_r       = '0;
            halt_r     = 1'b0;
            start_pc_r = 32'h0040_0000;
            pc_r       = start_pc_r;
            report_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) start_pc_r = cfg_ch.data;
            if (in_ch.valid && in_ch.ready) begin
                report_q.push_back(execute_word(in_ch.mode, in_ch.instr_word,
                                                in_ch.preload_index, in_ch.preload_data));
            end
            if (res_ch.valid && res_ch.ready) begin
                n_results++;
                if (report_q.size() == 0) begin
                    report_error("result word with no prediction waiting");
                end else begin
                    want = report_q.pop_front();
                    if (res_ch.pc_next !== want.pc_next)
                        report_error($sformatf("result %0d pc_next %h, predicted %h",
                                     n_results, res_ch.pc_next, want.pc_next));
                    if (res_ch.reg_write !== want.reg_write)
                        report_error($sformatf("result %0d reg_write %b, predicted %b",
                                     n_results, res_ch.reg_write, want.reg_write));
                    if (res_ch.reg_index !== want.reg_index)
                        report_error($sformatf("result %0d reg_index %0d, predicted %0d",
                                     n_results, res_ch.reg_index, want.reg_index));
                    if (res_ch.reg_value !== want.reg_value)
                        report_error($sformatf("result %0d reg_value %h, predicted %h",
                                     n_results, res_ch.reg_value, want.reg_value));
                    if (res_ch.mem_write !== want.mem_write)
                        report_error($sformatf("result %0d mem_write %b, predicted %b",
                                     n_results, res_ch.mem_write, want.mem_write));
                    if (res_ch.mem_byte_addr !== want.mem_byte_addr)
                        report_error($sformatf("result %0d mem_byte_addr %h, predicted %h",
                                     n_results, res_ch.mem_byte_addr, want.mem_byte_addr));
                    if (res_ch.halted !== want.halted)
                        report_error($sformatf("result %0d halted %b, predicted %b",
                                     n_results, res_ch.halted, want.halted));
                    if (res_ch.illegal !== want.illegal)
                        report_error($sformatf("result %0d illegal %b, predicted %b",
                                     n_results, res_ch.illegal, want.illegal));
                end
            end
        end
        pending = report_q.size();
    end

endmodule

[sim/tb.sv]
// Top of the testbench: clock, reset, stimulus and verdict for the MIPS32 execute block.
`timescale 1ns / 1ps
module tb;
    import mips32_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   open_count;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   hold_left = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   idle_cycles = 0;
    int   n_words = 0;
    int   n_cfg = 0;

    mips32_in_if  instr_ch ();
    mips32_out_if res_ch ();
    mips32_cfg_if cfg_ch ();

    always #4 clk = ~clk;

    mips32_instruction_execute_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    mips32_execute_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (instr_ch),
        .res_ch  (res_ch),
        .cfg_ch  (cfg_ch),
        .errors  (fail_count),
        .pending (open_count)
    );

    initial begin
        instr_ch.valid         = 1'b0;
        instr_ch.mode          = 1'b0;
        instr_ch.instr_word    = '0;
        instr_ch.preload_index = '0;
        instr_ch.preload_data  = '0;
        res_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.data            = '0;
    end

    always @(posedge clk) begin
        if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk) begin
        if ((instr_ch.valid && instr_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == 3000) begin
            $display("Timeout: no word moved for %0d cycles.", idle_cycles);
            $display("[mips32_instruction_execute_top] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sa);
        return {OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] pick_reg();
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [5:0]  alu_fns [20] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
                                      FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
                                      FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_MFHI, FN_MFLO,
                                      FN_MTHI, FN_MTLO};
        logic [5:0]  md_fns [4]   = '{FN_MULT, FN_MULTU, FN_DIV, FN_DIVU};
        logic [5:0]  imm_ops [8]  = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI,
                                      OP_ORI, OP_XORI, OP_LUI};
        logic [5:0]  ld_ops [5]   = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
        logic [5:0]  st_ops [3]   = '{OP_SB, OP_SH, OP_SW};
        logic [5:0]  br_ops [6]   = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
        logic [4:0]  ri_rts [4]   = '{RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL};
        logic [5:0]  bad_ops [8]  = '{6'h10, 6'h11, 6'h1c, 6'h22, 6'h26, 6'h2e, 6'h30, 6'h3f};
        logic [5:0]  bad_fns [8]  = '{6'h01, 6'h05, 6'h0a, 6'h0d, 6'h14, 6'h1c, 6'h2c, 6'h3f};
        logic [4:0]  bad_rts [4]  = '{5'h02, 5'h0c, 5'h12, 5'h1f};
        logic [31:0] w;
        int          k;
        k = $urandom_range(99);
        if (k < 30) begin
            w = rtype(alu_fns[$urandom_range(19)], pick_reg(), pick_reg(), pick_reg(),
                      5'($urandom));
        end else if (k < 36) begin
            w = rtype(md_fns[$urandom_range(3)], pick_reg(),
                      ($urandom_range(4) == 0) ? 5'd0 : pick_reg(), 5'd0, 5'd0);
        end else if (k < 50) begin
            w = itype(imm_ops[$urandom_range(7)], pick_reg(), pick_reg(), pick_imm());
        end else if (k < 62) begin
            w = itype(ld_ops[$urandom_range(4)], ($urandom_range(2) == 0) ? 5'd0 : pick_reg(),
                      pick_reg(), pick_imm());
        end else if (k < 72) begin
            w = itype(st_ops[$urandom_range(2)], ($urandom_range(2) == 0) ? 5'd0 : pick_reg(),
                      pick_reg(), pick_imm());
        end else if (k < 80) begin
            w = itype(br_ops[$urandom_range(5)], pick_reg(), pick_reg(), pick_imm());
            w[25:0] = ($urandom_range(3) == 0) ? 26'h3ffffff : w[25:0];
        end else if (k < 84) begin
            w = itype(OP_REGIMM, pick_reg(), ri_rts[$urandom_range(3)], pick_imm());
        end else if (k < 86) begin
            w = rtype(($urandom_range(1) == 0) ? FN_JR : FN_JALR, pick_reg(), 5'd0,
                      pick_reg(), 5'd0);
        end else if (k < 94) begin
            do w = $urandom; while (w[31:26] == OP_SPECIAL && w[5:0] == FN_SYSCALL);
        end else if (k < 96) begin
            w = {bad_ops[$urandom_range(7)], 26'($urandom)};
        end else if (k < 98) begin
            w = rtype(bad_fns[$urandom_range(7)], pick_reg(), pick_reg(), pick_reg(),
                      pick_reg());
        end else begin
            w = itype(OP_REGIMM, pick_reg(), bad_rts[$urandom_range(3)], pick_imm());
        end
        return w;
    endfunction

    task automatic send_word(logic mode, logic [31:0] iw, logic [9:0] pidx,
                             logic [31:0] pdata);
        if ($urandom_range(99) < send_idle) begin
            instr_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        instr_ch.valid         <= 1'b1;
        instr_ch.mode          <= mode;
        instr_ch.instr_word    <= iw;
        instr_ch.preload_index <= pidx;
        instr_ch.preload_data  <= pdata;
        @(negedge clk);
        while (!instr_ch.ready) @(negedge clk);
        @(posedge clk);
        n_words++;
    endtask

    task automatic run_instruction(logic [31:0] iw);
        send_word(1'b0, iw, 10'($urandom), $urandom);
    endtask

    task automatic drain();
        instr_ch.valid <= 1'b0;
        @(negedge clk);
        while (open_count != 0) @(negedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_start_pc(logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(negedge clk);
        while (!cfg_ch.ready) @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        n_cfg++;
    endtask

    initial begin
        logic [31:0] phase_pc [3] = '{32'hffff_ffff, 32'h0000_0000, 32'h0040_0000};
        int          phase_idle_send [3] = '{23, 58, 0};
        int          phase_idle_recv [3] = '{58, 23, 0};
        logic [15:0] v0_imm;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_start_pc($urandom);
        for (int i = 0; i < 1024; i++) begin
            send_word(1'b1, $urandom, 10'(i),
                      (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hffff_ffff : $urandom);
        end

        run_instruction(itype(OP_LUI, 5'd0, 5'd1, 16'h8000));
        run_instruction(itype(OP_ADDIU, 5'd0, 5'd3, 16'hffff));
        run_instruction(rtype(FN_DIV, 5'd1, 5'd3, 5'd0, 5'd0));
        run_instruction(rtype(FN_MFLO, 5'd0, 5'd0, 5'd4, 5'd0));
        run_instruction(rtype(FN_MFHI, 5'd0, 5'd0, 5'd5, 5'd0));
        run_instruction(rtype(FN_DIVU, 5'd3, 5'd0, 5'd0, 5'd0));
        run_instruction(rtype(FN_MFHI, 5'd0, 5'd0, 5'd6, 5'd0));
        run_instruction(rtype(FN_MULT, 5'd1, 5'd3, 5'd0, 5'd0));
        run_instruction(rtype(FN_MFHI, 5'd0, 5'd0, 5'd7, 5'd0));
        run_instruction(rtype(FN_MULTU, 5'd1, 5'd3, 5'd0, 5'd0));
        run_instruction(rtype(FN_MFLO, 5'd0, 5'd0, 5'd8, 5'd0));
        run_instruction(itype(OP_ADDIU, 5'd3, 5'd0, 16'h0005));
        run_instruction(rtype(FN_SRA, 5'd0, 5'd1, 5'd9, 5'd31));
        run_instruction(rtype(FN_SLT, 5'd1, 5'd3, 5'd10, 5'd0));
        run_instruction(itype(OP_LH, 5'd0, 5'd11, 16'h0003));
        run_instruction(itype(OP_LW, 5'd0, 5'd12, 16'h0005));
        run_instruction(itype(OP_SB, 5'd0, 5'd3, 16'h0001));
        run_instruction(itype(OP_SH, 5'd0, 5'd3, 16'h0003));
        run_instruction(itype(OP_SW, 5'd0, 5'd1, 16'hfffc));
        run_instruction(itype(OP_LB, 5'd0, 5'd13, 16'h0001));
        run_instruction(itype(OP_LHU, 5'd0, 5'd14, 16'h0002));
        run_instruction(itype(OP_LBU, 5'd0, 5'd15, 16'hfffd));
        run_instruction(itype(OP_REGIMM, 5'd1, RT_BLTZAL, 16'h0010));
        run_instruction(itype(OP_REGIMM, 5'd1, RT_BGEZAL, 16'h8000));
        run_instruction(itype(OP_BLEZ, 5'd0, 5'd0, 16'h7fff));
        run_instruction(itype(OP_BGTZ, 5'd1, 5'd0, 16'h0004));
        run_instruction({OP_JAL, 26'h3ffffff});
        run_instruction(rtype(FN_JALR, 5'd1, 5'd0, 5'd16, 5'd0));
        run_instruction({OP_J, 26'h0000000});
        run_instruction({6'h3f, 26'h3ffffff});

        for (int phase = 0; phase < 3; phase++) begin
            drain();
            write_start_pc(phase_pc[phase]);
            send_idle = phase_idle_send[phase];
            recv_idle = phase_idle_recv[phase];
            for (int i = 0; i < 270; i++) begin
                if (phase == 0 && i == 100) hold_go = 1'b1;
                if ($urandom_range(49) == 0) begin
                    // A non-exit system call keeps the core running.
                    do v0_imm = 16'($urandom); while (v0_imm == 16'(EXIT_CODE));
                    run_instruction(itype(OP_ADDIU, 5'd0, REG_V0, v0_imm));
                    run_instruction({OP_SPECIAL, 20'($urandom), FN_SYSCALL});
                end else if ($urandom_range(19) == 0) begin
                    send_word(1'b1, $urandom, 10'($urandom), $urandom);
                end else begin
                    run_instruction(random_instruction());
                end
            end
        end

        run_instruction(itype(OP_ADDIU, 5'd0, REG_V0, 16'(EXIT_CODE)));
        run_instruction({OP_SPECIAL, 20'($urandom), FN_SYSCALL});
        repeat (3) run_instruction(random_instruction());
        send_word(1'b1, $urandom, 10'($urandom), $urandom);
        run_instruction(random_instruction());
        drain();

        $display("Run covered %0d words (preloads, directed corner cases, random programs) ",
                 n_words);
        $display("across three idle settings and one long result stall, with %0d start_pc writes.",
                 n_cfg);
        if (fail_count == 0) begin
            $display("[mips32_instruction_execute_top] OK");
        end else begin
            $display("[mips32_instruction_execute_top] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mips32_pkg.sv
rtl/mips32_if.sv
rtl/mips32_ram.sv
rtl/mips32_md.sv
rtl/mips32_instruction_execute_top.sv
sim/mips32_execute_checker.sv
sim/tb.sv
